/* sv/assert_macros.svh */
// Assertion macros shared by the line pixel generator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define LPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpg assertion failed");
// Next-cycle implication, checked outside reset.
`define LPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpg assertion failed");
`else
`define LPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/lpg_pkg.sv */
// Package for the line pixel generator: widths, codes and the command beat type.
// No dependencies.
`default_nettype none
package lpg_pkg;

    localparam int COORD_BITS = 11;
    localparam int IN_W       = 12;
    localparam int PIX_W      = 11;
    localparam int DIM_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int ERR_W      = 15;
    localparam int INC_S_W    = 14;
    localparam int CNT_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 2;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << COORD_BITS) - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [DIM_W-1:0] PLANE_WIDTH_RST  = DIM_W'(320);
    localparam logic [DIM_W-1:0] PLANE_HEIGHT_RST = DIM_W'(240);

    typedef enum logic [1:0] {
        KIND_LINE,
        KIND_REJECT,
        KIND_ADVANCE
    } lpg_kind_t;

    typedef struct packed {
        lpg_kind_t                 kind;
        logic [DIM_W-1:0]          x;
        logic [DIM_W-1:0]          y;
        logic signed [ERR_W-1:0]   err;
        logic [INC_S_W-1:0]        inc_s;
        logic signed [ERR_W-1:0]   inc_d;
        logic [7:0]                dirs;
        logic [CNT_W-1:0]          count;
        logic [COLOR_W-1:0]        color;
    } lpg_cmd_t;

endpackage
`default_nettype wire

/* sv/lpg_front.sv */
// Front end: plane size registers, endpoint check and Bresenham setup.
// Depends on lpg_pkg.
`default_nettype none
module lpg_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpg_pkg::DIM_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [lpg_pkg::IN_W-1:0]    start_x,
    input  wire logic [lpg_pkg::IN_W-1:0]    start_y,
    input  wire logic [lpg_pkg::IN_W-1:0]    end_x,
    input  wire logic [lpg_pkg::IN_W-1:0]    end_y,
    input  wire logic [lpg_pkg::COLOR_W-1:0] pixel_color,
    input  wire logic                        q_full,
    output logic                             push,
    output lpg_pkg::lpg_cmd_t                cmd
);
    import lpg_pkg::*;

    logic [DIM_W-1:0] plane_width_reg;
    logic [DIM_W-1:0] plane_height_reg;

    logic             bad;
    logic [PIX_W-1:0] x1, y1, x2, y2;
    logic [PIX_W-1:0] dx, dy, maj, mnr;
    logic             xneg, yneg, major_x;
    logic signed [ERR_W-1:0] maj_s, mnr_s, diff_s;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= PLANE_WIDTH_RST;
            plane_height_reg <= PLANE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PLANE_WIDTH:  plane_width_reg  <= cfg_data;
                CFG_PLANE_HEIGHT: plane_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        // Negative coordinates fail on the sign bit; others compare unsigned.
        bad = start_x[IN_W-1] || start_y[IN_W-1] || end_x[IN_W-1] || end_y[IN_W-1] ||
              (start_x >= plane_width_reg) || (end_x >= plane_width_reg) ||
              (start_y >= plane_height_reg) || (end_y >= plane_height_reg);

        x1 = start_x[PIX_W-1:0];
        y1 = start_y[PIX_W-1:0];
        x2 = end_x[PIX_W-1:0];
        y2 = end_y[PIX_W-1:0];

        // Straight lines run from the lower coordinate upward.
        if (x1 == x2 && y1 > y2)
        begin
            y1 = end_y[PIX_W-1:0];
            y2 = start_y[PIX_W-1:0];
        end
        if (y1 == y2 && x1 > x2)
        begin
            x1 = end_x[PIX_W-1:0];
            x2 = start_x[PIX_W-1:0];
        end

        xneg    = x1 > x2;
        yneg    = y1 > y2;
        dx      = xneg ? x1 - x2 : x2 - x1;
        dy      = yneg ? y1 - y2 : y2 - y1;
        major_x = dx >= dy;
        maj     = major_x ? dx : dy;
        mnr     = major_x ? dy : dx;

        maj_s  = $signed({{(ERR_W-PIX_W){1'b0}}, maj});
        mnr_s  = $signed({{(ERR_W-PIX_W){1'b0}}, mnr});
        diff_s = mnr_s - maj_s;

        cmd       = '0;
        cmd.color = pixel_color;
        cmd.x     = {1'b0, x1};
        cmd.y     = {1'b0, y1};
        cmd.count = {1'b0, maj};
        cmd.inc_s = {{(INC_S_W-PIX_W-1){1'b0}}, mnr, 1'b0};
        cmd.err   = (mnr_s <<< 1) - maj_s;
        cmd.inc_d = diff_s <<< 1;
        // dirs: {diag y, diag x, straight y, straight x}, each {negative, moves}
        cmd.dirs  = {yneg, 1'b1, xneg, 1'b1,
                     yneg && !major_x, !major_x, xneg && major_x, major_x};
        if (operation == OP_ADVANCE)
            cmd.kind = KIND_ADVANCE;
        else if (bad)
            cmd.kind = KIND_REJECT;
        else
            cmd.kind = KIND_LINE;
    end

endmodule
`default_nettype wire

/* sv/lpg_queue.sv */
// Short command queue between the front end and the pixel walker.
// Depends on lpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lpg_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lpg_pkg::lpg_cmd_t wr_cmd,
    output logic                  full,
    input  wire logic             pop,
    output logic                  rd_valid,
    output lpg_pkg::lpg_cmd_t     rd_cmd
);
    import lpg_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    lpg_cmd_t          mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = count_reg == CNT_QW'(QDEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_QW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_QW'(1);
        end
    end

    `LPG_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `LPG_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, rd_valid)
    `LPG_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_QW'(QDEPTH))

endmodule
`default_nettype wire

/* sv/lpg_back.sv */
// Back end: Bresenham walker state and the registered pixel output.
// Depends on lpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lpg_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    input  wire lpg_pkg::lpg_cmd_t        q_cmd,
    output logic                          q_pop,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          status,
    output logic [lpg_pkg::PIX_W-1:0]     pixel_x,
    output logic [lpg_pkg::PIX_W-1:0]     pixel_y,
    output logic [lpg_pkg::COLOR_W-1:0]   out_color,
    output logic                          last_pixel
);
    import lpg_pkg::*;

    logic                    active_reg, active_next;
    logic [DIM_W-1:0]        cur_x_reg, cur_x_next;
    logic [DIM_W-1:0]        cur_y_reg, cur_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [INC_S_W-1:0]      inc_s_reg, inc_s_next;
    logic signed [ERR_W-1:0] inc_d_reg, inc_d_next;
    logic [7:0]              dirs_reg, dirs_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic [COLOR_W-1:0]      color_reg, color_next;

    logic                    ov_reg, ov_next;
    logic                    st_reg, st_next;
    logic [PIX_W-1:0]        px_reg, px_next;
    logic [PIX_W-1:0]        py_reg, py_next;
    logic [COLOR_W-1:0]      oc_reg, oc_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic [1:0]              bx, by;

    function automatic logic [DIM_W-1:0] step_coord(input logic [DIM_W-1:0] c,
                                                    input logic [1:0] bits);
        if (!bits[0])
            step_coord = c;
        else if (bits[1])
            step_coord = c - DIM_W'(1);
        else
            step_coord = c + DIM_W'(1);
    endfunction

    assign out_free   = !ov_reg || !out_stall;
    assign q_pop      = q_valid && out_free;
    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign out_color  = oc_reg;
    assign last_pixel = last_reg;

    always_comb
    begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        inc_s_next  = inc_s_reg;
        inc_d_next  = inc_d_reg;
        dirs_next   = dirs_reg;
        left_next   = left_reg;
        color_next  = color_reg;
        ov_next     = ov_reg && out_stall;
        st_next     = st_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        oc_next     = oc_reg;
        last_next   = last_reg;
        bx          = err_reg[ERR_W-1] ? dirs_reg[1:0] : dirs_reg[5:4];
        by          = err_reg[ERR_W-1] ? dirs_reg[3:2] : dirs_reg[7:6];

        if (q_pop)
        begin
            case (q_cmd.kind)
                KIND_REJECT:
                begin
                    // Drop any line in progress and report the bad start.
                    active_next = 1'b0;
                    ov_next     = 1'b1;
                    st_next     = 1'b1;
                    px_next     = '0;
                    py_next     = '0;
                    oc_next     = '0;
                    last_next   = 1'b0;
                end
                KIND_LINE:
                begin
                    active_next = q_cmd.count != '0;
                    cur_x_next  = q_cmd.x;
                    cur_y_next  = q_cmd.y;
                    err_next    = q_cmd.err;
                    inc_s_next  = q_cmd.inc_s;
                    inc_d_next  = q_cmd.inc_d;
                    dirs_next   = q_cmd.dirs;
                    left_next   = q_cmd.count;
                    color_next  = q_cmd.color;
                    ov_next     = 1'b1;
                    st_next     = 1'b0;
                    px_next     = q_cmd.x[PIX_W-1:0] & PIX_MASK;
                    py_next     = q_cmd.y[PIX_W-1:0] & PIX_MASK;
                    oc_next     = q_cmd.color;
                    last_next   = q_cmd.count == '0;
                end
                KIND_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        // Negative error: straight step, otherwise diagonal.
                        err_next    = err_reg[ERR_W-1]
                                    ? err_reg + $signed({1'b0, inc_s_reg})
                                    : err_reg + inc_d_reg;
                        cur_x_next  = step_coord(cur_x_reg, bx);
                        cur_y_next  = step_coord(cur_y_reg, by);
                        left_next   = left_reg - CNT_W'(1);
                        active_next = left_next != '0;
                        ov_next     = 1'b1;
                        st_next     = 1'b0;
                        px_next     = cur_x_next[PIX_W-1:0] & PIX_MASK;
                        py_next     = cur_y_next[PIX_W-1:0] & PIX_MASK;
                        oc_next     = color_reg;
                        last_next   = left_next == '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        err_reg   <= err_next;
        inc_s_reg <= inc_s_next;
        inc_d_reg <= inc_d_next;
        dirs_reg  <= dirs_next;
        left_reg  <= left_next;
        color_reg <= color_next;
        st_reg    <= st_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        oc_reg    <= oc_next;
        last_reg  <= last_next;
    end

    `LPG_ASSERT_NXT(a_reject_drops, clk, rst_n, q_pop && q_cmd.kind == KIND_REJECT, !active_reg && ov_reg && st_reg)
    `LPG_ASSERT_IMP(a_last_idle, clk, rst_n, ov_reg && last_reg, !active_reg)
    `LPG_ASSERT_NXT(a_hold_no_pop, clk, rst_n, !q_pop, $stable(active_reg))

endmodule
`default_nettype wire

/* sv/line_pixel_generator_top.sv */
// Top level of the Bresenham line pixel generator.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
`default_nettype none
// Line pixel generator. Send a start beat (operation 0) with two endpoints
// and a color; it yields the first pixel of the line at once. Each advance
// beat (operation 1) yields the next pixel, walking the major axis with the
// Bresenham error term, and the final endpoint carries last_pixel. An
// advance with no line active yields nothing. A start whose endpoints are
// negative or not below plane_width / plane_height (config registers 0 and
// 1, reset 320 and 240) yields one beat with status 1 and zeroed fields and
// drops any line in progress; a new start likewise replaces an old line.
// Horizontal and vertical lines are emitted from the lower coordinate up.
// Throughput is one input beat and one pixel per clock while out_stall is
// low: the front end checks and sets up a start combinationally, a two-entry
// queue decouples it from the walker, and the walker updates its error term
// once per advance beat. Stall on the output backs up into the queue;
// in_stall rises only when the queue is full. Write config only while the
// block is idle.
module line_pixel_generator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lpg_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [lpg_pkg::IN_W-1:0]      start_x,
    input  wire logic [lpg_pkg::IN_W-1:0]      start_y,
    input  wire logic [lpg_pkg::IN_W-1:0]      end_x,
    input  wire logic [lpg_pkg::IN_W-1:0]      end_y,
    input  wire logic [lpg_pkg::COLOR_W-1:0]   pixel_color,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               status,
    output logic [lpg_pkg::PIX_W-1:0]          pixel_x,
    output logic [lpg_pkg::PIX_W-1:0]          pixel_y,
    output logic [lpg_pkg::COLOR_W-1:0]        out_color,
    output logic                               last_pixel
);
    import lpg_pkg::*;

    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    lpg_cmd_t wr_cmd;
    lpg_cmd_t rd_cmd;

    // Classify each beat and precompute the line setup.
    lpg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .pixel_color (pixel_color),
        .q_full      (q_full),
        .push        (push),
        .cmd         (wr_cmd)
    );

    // Hold commands while the output register is stalled.
    lpg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_cmd   (wr_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (rd_cmd)
    );

    // Walk the line and drive the registered pixel beat.
    lpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (rd_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_color  (out_color),
        .last_pixel (last_pixel)
    );

endmodule
`default_nettype wire
